FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks, disabled while reset is held.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/lalb_pkg.sv
// ---------------------------------------------------------------------------
// lalb_pkg
// Constants, stage map and word type of the additive layer blend pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package lalb_pkg;

  localparam int FRAC_BITS = 15;
  localparam logic [15:0] ONE = 16'(1 << FRAC_BITS);

  // stage map
  localparam int ST_IN      = 0;
  localparam int ST_COMP    = 1;
  localparam int ST_MASK    = 2;
  localparam int ST_NEW     = 3;
  localparam int ST_DIV0    = 4;
  localparam int DIV_STAGES = 5;
  localparam int DIV_STEPS  = FRAC_BITS / DIV_STAGES;
  localparam int ST_MUL     = ST_DIV0 + DIV_STAGES;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int NUM_ST     = ST_OUT + 1;

  typedef enum logic [0:0] {
    REG_OPACITY = 1'b0,
    REG_MASK_EN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [3:0][15:0]          base;     // r, g, b, alpha
    logic [2:0][15:0]          layer;
    logic [15:0]               amin;
    logic [15:0]               mask;
    logic                      last;
    logic [15:0]               comp;
    logic [16:0]               newa;
    logic [16:0]               rem;
    logic [FRAC_BITS-1:0]      quo;
    logic                      pass;
    logic                      cap;
    logic [2:0][31:0]          p1;
    logic [2:0][31:0]          p2;
    logic [2:0][15:0]          res;
  } pipe_t;

  function automatic logic [15:0] sat_one(input logic [15:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/legacy_addition_layer_blend.sv
// ---------------------------------------------------------------------------
// legacy_addition_layer_blend
// Additive layer blend of Q1.15 RGBA pixels with opacity and optional mask.
//
//   channel | handshake              | word
//   --------+------------------------+---------------------------------------
//   in      | in_valid / in_ready    | base RGBA, layer RGBA, mask, last
//   out     | out_valid / out_ready  | result RGBA, last
//   cfg     | cfg_we                 | cfg_index, cfg_data (no wait)
//
// 11-stage pipeline, one word per cycle while out_ready is high. The quotient
// comp/new alpha takes five stages, three bits each. Synchronous active-low
// reset clears stage valids and mask enable, and sets opacity to one.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles are squeezed out and in_ready stays high while any stage is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module legacy_addition_layer_blend (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_base_red,
  input  wire logic [15:0] in_base_green,
  input  wire logic [15:0] in_base_blue,
  input  wire logic [15:0] in_base_alpha,
  input  wire logic [15:0] in_layer_red,
  input  wire logic [15:0] in_layer_green,
  input  wire logic [15:0] in_layer_blue,
  input  wire logic [15:0] in_layer_alpha,
  input  wire logic [15:0] in_mask_value,
  input  wire logic        in_pixel_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_result_red,
  output logic [15:0]      out_result_green,
  output logic [15:0]      out_result_blue,
  output logic [15:0]      out_result_alpha,
  output logic             out_result_last
);

  localparam int NS = lalb_pkg::NUM_ST;
  localparam int FB = lalb_pkg::FRAC_BITS;

  logic [15:0]                 opacity_r;
  logic                        mask_en_r;
  logic [15:0]                 op_sat;
  logic [NS-1:0]               vld_r;
  logic [NS-1:0]               rdy;
  lalb_pkg::pipe_t             stg_r   [NS];
  lalb_pkg::pipe_t             stg_nxt [NS];

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r <= lalb_pkg::ONE;
      mask_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (lalb_pkg::reg_idx_t'(cfg_index))
        lalb_pkg::REG_OPACITY: opacity_r <= cfg_data;
        lalb_pkg::REG_MASK_EN: mask_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign op_sat = lalb_pkg::sat_one(opacity_r);

  // per-stage ready
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  // stage datapath
  always_comb begin
    lalb_pkg::pipe_t t;
    logic [31:0]     mul;
    logic [17:0]     rem_s;
    logic [15:0]     ratio;
    logic [16:0]     sum;
    logic [15:0]     sum_c;
    logic [31:0]     acc;

    // input: saturate fields
    t          = '0;
    t.base[0]  = lalb_pkg::sat_one(in_base_red);
    t.base[1]  = lalb_pkg::sat_one(in_base_green);
    t.base[2]  = lalb_pkg::sat_one(in_base_blue);
    t.base[3]  = lalb_pkg::sat_one(in_base_alpha);
    t.layer[0] = lalb_pkg::sat_one(in_layer_red);
    t.layer[1] = lalb_pkg::sat_one(in_layer_green);
    t.layer[2] = lalb_pkg::sat_one(in_layer_blue);
    t.amin     = (t.base[3] < lalb_pkg::sat_one(in_layer_alpha)) ?
                 t.base[3] : lalb_pkg::sat_one(in_layer_alpha);
    t.mask     = lalb_pkg::sat_one(in_mask_value);
    t.last     = in_pixel_last;
    stg_nxt[lalb_pkg::ST_IN] = t;

    // min alpha * opacity
    t      = stg_r[lalb_pkg::ST_IN];
    mul    = 32'(t.amin) * 32'(op_sat);
    t.comp = mul[FB+15:FB];
    stg_nxt[lalb_pkg::ST_COMP] = t;

    // optional mask
    t   = stg_r[lalb_pkg::ST_COMP];
    mul = 32'(t.comp) * 32'(t.mask);
    if (mask_en_r) begin
      t.comp = mul[FB+15:FB];
    end
    stg_nxt[lalb_pkg::ST_MASK] = t;

    // new alpha
    t      = stg_r[lalb_pkg::ST_MASK];
    mul    = 32'(lalb_pkg::ONE - t.base[3]) * 32'(t.comp);
    t.newa = {1'b0, t.base[3]} + {1'b0, mul[FB+15:FB]};
    stg_nxt[lalb_pkg::ST_NEW] = t;

    // restoring divide, DIV_STEPS quotient bits per stage
    for (int s = 0; s < lalb_pkg::DIV_STAGES; s++) begin
      t = stg_r[lalb_pkg::ST_DIV0 + s - 1];
      if (s == 0) begin
        t.pass = (t.comp == '0) || (t.newa == '0);
        t.cap  = {1'b0, t.comp} >= t.newa;
        t.rem  = {1'b0, t.comp};
        t.quo  = '0;
      end
      for (int b = 0; b < lalb_pkg::DIV_STEPS; b++) begin
        rem_s = {t.rem, 1'b0};
        if (rem_s >= {1'b0, t.newa}) begin
          rem_s = rem_s - {1'b0, t.newa};
          t.quo = {t.quo[FB-2:0], 1'b1};
        end else begin
          t.quo = {t.quo[FB-2:0], 1'b0};
        end
        t.rem = rem_s[16:0];
      end
      stg_nxt[lalb_pkg::ST_DIV0 + s] = t;
    end

    // channel products
    t     = stg_r[lalb_pkg::ST_MUL - 1];
    ratio = t.cap ? lalb_pkg::ONE : {1'b0, t.quo};
    for (int c = 0; c < 3; c++) begin
      sum     = {1'b0, t.base[c]} + {1'b0, t.layer[c]};
      sum_c   = (sum > {1'b0, lalb_pkg::ONE}) ? lalb_pkg::ONE : sum[15:0];
      t.p1[c] = 32'(sum_c) * 32'(ratio);
      t.p2[c] = 32'(t.base[c]) * 32'(lalb_pkg::ONE - ratio);
    end
    stg_nxt[lalb_pkg::ST_MUL] = t;

    // sum and select
    t = stg_r[lalb_pkg::ST_MUL];
    for (int c = 0; c < 3; c++) begin
      acc      = t.p1[c] + t.p2[c];
      t.res[c] = t.pass ? t.base[c] : acc[FB+15:FB];
    end
    stg_nxt[lalb_pkg::ST_OUT] = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (rdy[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_valid        = vld_r[NS-1];
  assign out_result_red   = stg_r[NS-1].res[0];
  assign out_result_green = stg_r[NS-1].res[1];
  assign out_result_blue  = stg_r[NS-1].res[2];
  assign out_result_alpha = stg_r[NS-1].base[3];
  assign out_result_last  = stg_r[NS-1].last;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && in_ready, vld_r[0])
  `ASSERT_IMPL(a_full_blocks, clk, rst_n, (&vld_r) && !out_ready, !in_ready)
  `ASSERT_IMPL(a_div_rem, clk, rst_n,
    vld_r[lalb_pkg::ST_MUL-1] && !stg_r[lalb_pkg::ST_MUL-1].pass
      && !stg_r[lalb_pkg::ST_MUL-1].cap,
    stg_r[lalb_pkg::ST_MUL-1].rem < stg_r[lalb_pkg::ST_MUL-1].newa)
  `ASSERT_IMPL(a_out_range, clk, rst_n, out_valid,
    (out_result_red <= lalb_pkg::ONE) && (out_result_green <= lalb_pkg::ONE)
      && (out_result_blue <= lalb_pkg::ONE))

endmodule

`default_nettype wire
